FILE: rtl/core/ifp_pkg.sv
`timescale 1ns / 1ps

package ifp_pkg;

   localparam int unsigned LenWidth   = 16;
   localparam int unsigned CountWidth = 6;

   localparam logic [LenWidth-1:0] MinHeader   = 16'd20;
   localparam logic [LenWidth-1:0] MinFragment = 16'd8;
   localparam logic [2:0]          AlignMask   = 3'h7;

   localparam logic [LenWidth-1:0]   MtuReset      = 16'd1500;
   localparam logic [CountWidth-1:0] MaxFragsReset = 6'd63;

   typedef enum logic {
      CSR_MTU       = 1'b0,
      CSR_MAX_FRAGS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD_HDR = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_MTU     = 3'd3,
      ST_FIRST   = 3'd4,
      ST_MANY    = 3'd5
   } status_type;

endpackage

FILE: rtl/core/ipv4_fragment_planner.sv
`timescale 1ns / 1ps

// channel   ports                                        handshake
// request   req_header_len, req_payload_len              start while busy is low
// result    rsp_frag_offset, rsp_frag_len, rsp_more_frags,
//           rsp_status, rsp_last                         rsp_valid for one cycle
// config    csr_index, csr_write_data                    csr_write_en
//
// one subtractor is shared: first it forms mtu - header_len, then payload - offset
// a request runs through S_CHECK, S_COUNT and S_EMIT, emitting one word per
// fragment (error runs stop early); words come one per cycle during emit
// the counting pass runs first so a rejection never leaves partial descriptors
// synchronous reset sets mtu to 1500 and the fragment cap to 63
// the receiver cannot stall: each word is shown for exactly one cycle
module ipv4_fragment_planner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ifp_pkg::LenWidth-1:0]        req_header_len,
   input  logic [ifp_pkg::LenWidth-1:0]        req_payload_len,
   output logic                                rsp_valid,
   output logic [ifp_pkg::LenWidth-1:0]        rsp_frag_offset,
   output logic [ifp_pkg::LenWidth-1:0]        rsp_frag_len,
   output logic                                rsp_more_frags,
   output ifp_pkg::status_type                 rsp_status,
   output logic                                rsp_last,
   input  logic                                csr_write_en,
   input  ifp_pkg::csr_index_type              csr_index,
   input  logic [ifp_pkg::LenWidth-1:0]        csr_write_data
);
   import ifp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_COUNT,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [LenWidth-1:0]     mtu_ff;
   logic [CountWidth-1:0]   max_frags_ff;
   logic [LenWidth-1:0]     hdr_ff, hdr_in;
   logic [LenWidth-1:0]     total_ff, total_in;
   logic [LenWidth-1:0]     room_ff, room_in;
   logic [LenWidth-1:0]     off_ff, off_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in;

   logic                    valid_ff, valid_in;
   logic [LenWidth-1:0]     offset_ff, offset_in;
   logic [LenWidth-1:0]     len_ff, len_in;
   logic                    more_ff, more_in;
   status_type              status_ff, status_in;
   logic                    last_ff, last_in;

   // shared subtractor
   logic [LenWidth-1:0]     sub_a, sub_b;
   logic [LenWidth:0]       diff;
   logic [LenWidth-1:0]     rest;
   logic [LenWidth-1:0]     step;
   logic                    fin;
   logic [LenWidth-1:0]     frag_len;

   always_comb begin
      if (state_ff == S_CHECK) begin
         sub_a = mtu_ff;
         sub_b = hdr_ff;
      end else begin
         sub_a = total_ff;
         sub_b = off_ff;
      end
      diff     = {1'b0, sub_a} - {1'b0, sub_b};
      rest     = diff[LenWidth-1:0];
      step     = {room_ff[LenWidth-1:3], 3'b000};
      fin      = (rest <= room_ff);
      frag_len = fin ? rest : step;
   end

   always_comb begin
      state_in  = state_ff;
      hdr_in    = hdr_ff;
      total_in  = total_ff;
      room_in   = room_ff;
      off_in    = off_ff;
      cnt_in    = cnt_ff;
      valid_in  = 1'b0;
      offset_in = '0;
      len_in    = '0;
      more_in   = 1'b0;
      status_in = ST_OK;
      last_in   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               hdr_in   = req_header_len;
               total_in = req_payload_len;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            room_in = rest;
            off_in  = '0;
            cnt_in  = '0;
            if (hdr_ff < MinHeader || hdr_ff[1:0] != 2'b00) begin
               status_in = ST_BAD_HDR;
            end else if (total_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (diff[LenWidth] || rest < MinFragment) begin
               // covers mtu not above the header too
               status_in = ST_MTU;
            end
            if (status_in != ST_OK) begin
               valid_in = 1'b1;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            // dry run of the split so that errors surface before any word
            if (cnt_ff >= max_frags_ff) begin
               status_in = ST_MANY;
            end else if (cnt_ff == '0 && fin && total_ff < MinFragment) begin
               status_in = ST_FIRST;
            end
            if (status_in != ST_OK) begin
               valid_in = 1'b1;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end else if (fin) begin
               off_in   = '0;
               state_in = S_EMIT;
            end else begin
               off_in = off_ff + step;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            valid_in  = 1'b1;
            offset_in = off_ff;
            len_in    = frag_len;
            more_in   = !fin;
            last_in   = fin;
            off_in    = off_ff + frag_len;
            if (fin) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= 1'b0;
         mtu_ff       <= MtuReset;
         max_frags_ff <= MaxFragsReset;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_MTU:       mtu_ff       <= csr_write_data;
               CSR_MAX_FRAGS: max_frags_ff <= csr_write_data[CountWidth-1:0];
               default:       mtu_ff       <= mtu_ff;
            endcase
         end
      end
      // word fields, no reset needed
      offset_ff <= offset_in;
      len_ff    <= len_in;
      more_ff   <= more_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      hdr_ff    <= hdr_in;
      total_ff  <= total_in;
      room_ff   <= room_in;
      off_ff    <= off_in;
      cnt_ff    <= cnt_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_frag_offset = offset_ff;
   assign rsp_frag_len    = len_ff;
   assign rsp_more_frags  = more_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

`ifndef SYNTHESIS
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_frag_len == '0
         && rsp_frag_offset == '0 && !rsp_more_frags)
      else $error("error word with descriptor fields set");

   a_mid_run_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_more_frags && rsp_status == ST_OK && busy)
      else $error("non-final word without more fragments or outside a run");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted request did not start a run");

   a_offset_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid
         && rsp_frag_offset == $past(rsp_frag_offset) + $past(rsp_frag_len))
      else $error("fragment offsets not contiguous");
`endif

endmodule

FILE: verif/ipv4_fragment_planner_test.sv
`timescale 1ns / 1ps

module ipv4_fragment_planner_test;
   import ifp_pkg::*;

   localparam int unsigned SettleCycles = 8;

   typedef struct {
      logic [LenWidth-1:0] offset;
      logic [LenWidth-1:0] length;
      logic                more;
      status_type          status;
      logic                is_last;
   } frag_word_type;

   typedef enum logic {
      ROW_LIMITS,
      ROW_PLAN
   } row_kind_type;

   // ROW_LIMITS: a = mtu, b = fragment cap
   // ROW_PLAN:   a = header length, b = payload length
   typedef struct {
      row_kind_type        kind;
      logic [LenWidth-1:0] a;
      logic [LenWidth-1:0] b;
      logic                typed;
      status_type          status;
   } plan_row_type;

   localparam int unsigned NumRows = 32;

   plan_row_type directed_rows [0:NumRows-1] = '{
      '{ROW_PLAN,   16'd20,    16'd100,   1'b1, ST_OK},
      '{ROW_PLAN,   16'd19,    16'd100,   1'b1, ST_BAD_HDR},
      '{ROW_PLAN,   16'd22,    16'd100,   1'b1, ST_BAD_HDR},
      '{ROW_PLAN,   16'd0,     16'd0,     1'b1, ST_BAD_HDR},
      '{ROW_PLAN,   16'hFFFF,  16'hFFFF,  1'b1, ST_BAD_HDR},
      '{ROW_PLAN,   16'd20,    16'd0,     1'b1, ST_EMPTY},
      '{ROW_PLAN,   16'd20,    16'd7,     1'b1, ST_FIRST},
      '{ROW_PLAN,   16'd20,    16'd8,     1'b1, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd1480,  1'b1, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd1481,  1'b0, ST_OK},
      '{ROW_PLAN,   16'd24,    16'd3000,  1'b0, ST_OK},
      '{ROW_PLAN,   16'd60,    16'hFFFF,  1'b0, ST_OK},
      '{ROW_PLAN,   16'd1496,  16'd100,   1'b1, ST_MTU},
      '{ROW_PLAN,   16'd1500,  16'd100,   1'b1, ST_MTU},
      '{ROW_PLAN,   16'hFFFC,  16'd1,     1'b1, ST_MTU},
      '{ROW_LIMITS, 16'd1500,  16'd1,     1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd1481,  1'b1, ST_MANY},
      '{ROW_PLAN,   16'd20,    16'd1480,  1'b1, ST_OK},
      '{ROW_LIMITS, 16'd1500,  16'd0,     1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd1,     1'b1, ST_MANY},
      '{ROW_LIMITS, 16'd0,     16'd63,    1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd5,     1'b1, ST_MTU},
      '{ROW_LIMITS, 16'd27,    16'd63,    1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd64,    1'b1, ST_MTU},
      '{ROW_LIMITS, 16'd28,    16'd63,    1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd504,   1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'd505,   1'b1, ST_MANY},
      '{ROW_PLAN,   16'd20,    16'hFFFF,  1'b1, ST_MANY},
      '{ROW_PLAN,   16'd20,    16'd7,     1'b1, ST_FIRST},
      '{ROW_LIMITS, 16'hFFFF,  16'd63,    1'b0, ST_OK},
      '{ROW_PLAN,   16'd20,    16'hFFFF,  1'b0, ST_OK},
      '{ROW_PLAN,   16'hFFFC,  16'd3,     1'b1, ST_MTU}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [LenWidth-1:0]   req_header_len;
   logic [LenWidth-1:0]   req_payload_len;
   logic                  rsp_valid;
   logic [LenWidth-1:0]   rsp_frag_offset;
   logic [LenWidth-1:0]   rsp_frag_len;
   logic                  rsp_more_frags;
   status_type            rsp_status;
   logic                  rsp_last;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [LenWidth-1:0]   csr_write_data;

   logic [LenWidth-1:0]   mtu_limit;
   logic [CountWidth-1:0] frag_cap;
   frag_word_type         pending_frags[$];
   int unsigned           error_count;
   int unsigned           request_count;
   int unsigned           descriptor_count;
   int unsigned           reject_count;

   ipv4_fragment_planner DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_header_len  (req_header_len),
      .req_payload_len (req_payload_len),
      .rsp_valid       (rsp_valid),
      .rsp_frag_offset (rsp_frag_offset),
      .rsp_frag_len    (rsp_frag_len),
      .rsp_more_frags  (rsp_more_frags),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic frag_word_type reject_word(input status_type code);
      frag_word_type w;
      w.offset  = '0;
      w.length  = '0;
      w.more    = 1'b0;
      w.status  = code;
      w.is_last = 1'b1;
      return w;
   endfunction

   // splits one packet under the current limits; a rejection replaces the whole run
   function automatic void plan_fragments(input logic [LenWidth-1:0] hdr,
                                          input logic [LenWidth-1:0] pay);
      frag_word_type run[$];
      frag_word_type w;
      status_type    verdict = ST_OK;
      int unsigned   room;
      int unsigned   offset = 0;
      int unsigned   count = 0;
      int unsigned   rest;
      int unsigned   len;
      logic          fin;
      if (hdr < MinHeader || hdr[1:0] != 2'b00)
         verdict = ST_BAD_HDR;
      else if (pay == 0)
         verdict = ST_EMPTY;
      else if (mtu_limit <= hdr || int'(mtu_limit) - int'(hdr) < int'(MinFragment))
         verdict = ST_MTU;
      else begin
         room = int'(mtu_limit) - int'(hdr);
         while (offset < int'(pay) && verdict == ST_OK) begin
            if (count >= frag_cap) begin
               verdict = ST_MANY;
            end else begin
               rest = int'(pay) - offset;
               fin  = rest <= room;
               len  = fin ? rest : (room & ~32'(AlignMask));
               if (offset == 0 && len < MinFragment) begin
                  verdict = ST_FIRST;
               end else begin
                  w.offset  = offset[LenWidth-1:0];
                  w.length  = len[LenWidth-1:0];
                  w.more    = !fin;
                  w.status  = ST_OK;
                  w.is_last = fin;
                  run.push_back(w);
                  offset += len;
                  count++;
               end
            end
         end
      end
      if (verdict != ST_OK)
         pending_frags.push_back(reject_word(verdict));
      else
         foreach (run[i]) pending_frags.push_back(run[i]);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // payload sized to land around the fragment cap, sometimes past it
   function automatic logic [LenWidth-1:0] pick_payload(input logic [LenWidth-1:0] hdr);
      int unsigned room;
      int unsigned lim;
      if (mtu_limit <= hdr || int'(mtu_limit) - int'(hdr) < int'(MinFragment))
         return LenWidth'($urandom_range(1, 64));
      room = int'(mtu_limit) - int'(hdr);
      lim  = room * (int'(frag_cap) + 1);
      if (lim > 65535)
         lim = 65535;
      return LenWidth'($urandom_range(1, lim));
   endfunction

   task automatic drive_request(input logic [LenWidth-1:0] hdr,
                                input logic [LenWidth-1:0] pay,
                                input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_header_len  <= hdr;
      req_payload_len <= pay;
      do @(posedge clock); while (busy);
      request_count++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_frags.size() != 0 || busy) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // both registers are written every time, block must be idle
   task automatic set_limits(input logic [LenWidth-1:0] mtu, input logic [CountWidth-1:0] cap);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_MTU;
      csr_write_data <= mtu;
      @(posedge clock);
      csr_index      <= CSR_MAX_FRAGS;
      csr_write_data <= {{(LenWidth-CountWidth){1'b0}}, cap};
      @(posedge clock);
      csr_write_en   <= 1'b0;
      mtu_limit = mtu;
      frag_cap  = cap;
   endtask

   always @(posedge clock) begin : check_words
      frag_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_frags.size() == 0) begin
            $display("%0t: unexpected word off=%0d len=%0d mf=%0b st=%0d last=%0b", $time,
                     rsp_frag_offset, rsp_frag_len, rsp_more_frags, rsp_status, rsp_last);
            error_count++;
         end else begin
            want = pending_frags.pop_front();
            if (rsp_status == ST_OK)
               descriptor_count++;
            else
               reject_count++;
            if (rsp_frag_offset !== want.offset || rsp_frag_len !== want.length ||
                rsp_more_frags !== want.more || rsp_status !== want.status ||
                rsp_last !== want.is_last) begin
               $display("%0t: expected off=%0d len=%0d mf=%0b st=%0d last=%0b", $time,
                        want.offset, want.length, want.more, want.status, want.is_last);
               $display("%0t: actual   off=%0d len=%0d mf=%0b st=%0d last=%0b", $time,
                        rsp_frag_offset, rsp_frag_len, rsp_more_frags, rsp_status, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d words still outstanding", pending_frags.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      frag_word_type       w;
      logic [LenWidth-1:0] hdr;
      logic [LenWidth-1:0] pay;
      int unsigned         gap;
      error_count      = 0;
      request_count    = 0;
      descriptor_count = 0;
      reject_count     = 0;
      mtu_limit        = MtuReset;
      frag_cap         = MaxFragsReset;
      reset            = 1'b1;
      start            = 1'b0;
      req_header_len   = '0;
      req_payload_len  = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_MTU;
      csr_write_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_LIMITS) begin
            drain_results();
            set_limits(directed_rows[r].a, directed_rows[r].b[CountWidth-1:0]);
         end else begin
            drive_request(directed_rows[r].a, directed_rows[r].b, pick_gap());
            if (!directed_rows[r].typed) begin
               plan_fragments(directed_rows[r].a, directed_rows[r].b);
            end else if (directed_rows[r].status != ST_OK) begin
               pending_frags.push_back(reject_word(directed_rows[r].status));
            end else begin
               // single fragment carrying the whole payload
               w.offset  = '0;
               w.length  = directed_rows[r].b;
               w.more    = 1'b0;
               w.status  = ST_OK;
               w.is_last = 1'b1;
               pending_frags.push_back(w);
            end
         end
      end

      for (int phase = 0; phase < 5; phase++) begin
         drain_results();
         case (phase)
            0: set_limits(MtuReset, MaxFragsReset);
            1: set_limits(16'd576, CountWidth'($urandom_range(1, 63)));
            2: set_limits(16'hFFFF, MaxFragsReset);
            3: set_limits(LenWidth'($urandom_range(24, 200)), CountWidth'($urandom_range(0, 63)));
            default: set_limits(LenWidth'($urandom), CountWidth'($urandom_range(1, 63)));
         endcase
         for (int k = 0; k < 40; k++) begin
            // hold off now and then until the block has emptied
            if (k > 0 && $urandom_range(0, 19) == 0)
               drain_results();
            if ($urandom_range(0, 9) < 8) begin
               hdr = LenWidth'(20 + 4 * $urandom_range(0, 10));
               pay = pick_payload(hdr);
            end else begin
               hdr = LenWidth'($urandom);
               pay = LenWidth'($urandom);
            end
            gap = (phase == 0) ? 0 : pick_gap();
            drive_request(hdr, pay, gap);
            plan_fragments(hdr, pay);
         end
      end

      drain_results();
      $display("sent %0d packet requests over several mtu and fragment cap settings",
               request_count);
      $display("checked %0d fragment descriptors and %0d rejection words",
               descriptor_count, reject_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
